[sv/tdd_pkg.sv]
// ----------------------------------------------------------------------------
// tdd_pkg: shared types, constants and helpers of the threshold dwell decider
// Field widths, result codes, mode and register codes, the vote counter
// layout and the state encodings of the core and the serial average unit.
// ----------------------------------------------------------------------------
package tdd_pkg;

  // field widths
  localparam int ChanW    = 10;
  localparam int SampleW  = 16;
  localparam int TgtW     = 4;
  localparam int FracW    = 8;
  localparam int ValueW   = SampleW + FracW;
  localparam int CodeW    = 3;
  localparam int CntW     = 16;
  localparam int ModeW    = 3;
  localparam int ZbW      = 18;
  localparam int NumVotes = 9;

  // configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 18;

  // stream packing
  localparam int InDataW  = 24;
  localparam int InUserW  = ChanW + 3;
  localparam int OutBitsW = ValueW + CodeW + NumVotes * CntW;
  localparam int OutDataW = ((OutBitsW + 7) / 8) * 8;
  localparam int OutPadW  = OutDataW - OutBitsW;

  // serial multiply / divide of the running average
  localparam int DenW     = CntW + 1;
  localparam int ProdW    = ValueW + CntW;
  localparam int NumW     = ProdW + 1;
  localparam int MulSteps = CntW;
  localparam int DivSteps = ProdW;
  localparam int StepW    = $clog2(DivSteps);

  // result codes
  localparam logic [CodeW-1:0] CodeNone = 3'd0;
  localparam logic [CodeW-1:0] CodeNeg  = 3'd1;
  localparam logic [CodeW-1:0] CodeNeu  = 3'd2;
  localparam logic [CodeW-1:0] CodePos  = 3'd4;

  // code bit positions in target and code
  localparam int BitNeg = 0;
  localparam int BitNeu = 1;
  localparam int BitPos = 2;

  // decision modes
  localparam logic [ModeW-1:0] ModePass  = 3'd0;
  localparam logic [ModeW-1:0] ModeLast  = 3'd1;
  localparam logic [ModeW-1:0] ModeAvg   = 3'd2;
  localparam logic [ModeW-1:0] ModeThr   = 3'd3;
  localparam logic [ModeW-1:0] ModeDwell = 3'd4;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegMode     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDwell    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegChannel  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegNegThr   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegPosThr   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegZeroBand = 3'd5;

  // register reset values
  localparam logic [ModeW-1:0]   RstMode     = ModeAvg;
  localparam logic [CntW-1:0]    RstDwell    = 16'd8;
  localparam logic [ChanW-1:0]   RstChannel  = 10'd0;
  localparam logic [SampleW-1:0] RstNegThr   = 16'hFFB0;
  localparam logic [SampleW-1:0] RstPosThr   = 16'h0050;
  localparam logic [ZbW-1:0]     RstZeroBand = 18'd128;

  // vote counter slots
  localparam int VotePosRight = 0;
  localparam int VotePosWrong = 1;
  localparam int VoteNegRight = 2;
  localparam int VoteNegWrong = 3;
  localparam int VoteNeuRight = 4;
  localparam int VoteNeuWrong = 5;
  localparam int VoteTotRight = 6;
  localparam int VoteTotWrong = 7;
  localparam int VoteInvalid  = 8;

  typedef logic [NumVotes-1:0][CntW-1:0] vote_cnt_t;

  typedef struct packed {
    logic              fire;
    logic              artifact;
    logic [TgtW-1:0]   target;
    logic [CodeW-1:0]  code;
  } vote_req_t;

  typedef struct packed {
    logic                     start;
    logic signed [ValueW-1:0] value;
    logic [CntW-1:0]          count;
    logic signed [ValueW-1:0] sample;
  } avg_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [ValueW-1:0] quot;
  } avg_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_AVG,
    ST_VOTE,
    ST_PUSH
  } core_state_e;

  typedef enum logic [2:0] {
    AV_IDLE,
    AV_MUL,
    AV_SUM,
    AV_ABS,
    AV_DIV,
    AV_FIX
  } avg_state_e;

  // saturating increment of a block or vote count
  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] c);
    sat_inc = (c == {CntW{1'b1}}) ? c : CntW'(c + 1'b1);
  endfunction

  // classify a Q16.8 value against the neutral band
  function automatic logic [CodeW-1:0] code_from_value(input logic [ValueW-1:0] v,
                                                       input logic [ZbW-1:0]    zb);
    logic signed [ValueW:0] vx;
    logic signed [ValueW:0] zp;
    logic signed [ValueW:0] zn;
    vx = {v[ValueW-1], v};
    zp = {{(ValueW + 1 - ZbW){1'b0}}, zb};
    zn = -zp;
    if (vx > zp) begin
      code_from_value = CodePos;
    end else if (vx < zn) begin
      code_from_value = CodeNeg;
    end else begin
      code_from_value = CodeNeu;
    end
  endfunction

endpackage

[sv/threshold_dwell_decider_core.sv]
// ----------------------------------------------------------------------------
// threshold_dwell_decider_core: decision block for tagged channel samples
// Applies the configured decision mode to samples of one channel, keeps the
// Q16.8 decision value and code, and scores votes at the end of a class.
// ----------------------------------------------------------------------------
// Samples arrive as stream transfers tagged with a channel; a transfer on any
// other channel than decision_channel is taken and dropped without a result.
// A decision channel transfer gives one result transfer and occupies the block
// from acceptance until it is ready again, through EXEC, VOTE and PUSH, with
// AVG before VOTE in average mode, where the bit-serial multiplier (16 steps)
// and restoring divider (40 steps) of the average unit run. One item is worked
// on at a time; the output register holds a finished result while the next
// item is taken. Configuration is written through the plain write port while
// the block is idle: a rule for the user, not enforced by the block itself.
module threshold_dwell_decider_core
  import tdd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // sample stream in
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // sample[15:0], target_code[19:16], zero pad
  input  logic [InUserW-1:0]  s_axis_tuser,  // channel[9:0], begin_of_trial, classification,
                                             // artifact
  input  logic                s_axis_tlast,  // end_of_class_in
  // decision stream out
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,  // result_value[23:0], result_code[26:24],
                                             // pos_right, pos_wrong, neg_right, neg_wrong,
                                             // neutral_right, neutral_wrong, total_right,
                                             // total_wrong, total_invalid (16 bits each),
                                             // zero pad
  output logic                m_axis_tlast   // end_of_class_out
);

  // configuration registers
  logic [ModeW-1:0]   mode_q;
  logic [CntW-1:0]    dwell_q;
  logic [ChanW-1:0]   chan_q;
  logic [SampleW-1:0] neg_thr_q;
  logic [SampleW-1:0] pos_thr_q;
  logic [ZbW-1:0]     zb_q;

  // held item
  logic [SampleW-1:0] sample_q;
  logic [TgtW-1:0]    tgt_q;
  logic               bot_q;
  logic               cls_q;
  logic               art_q;
  logic               eoc_in_q;

  // decision state
  core_state_e              state_q, state_d;
  logic signed [ValueW-1:0] dv_q, dv_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [CodeW-1:0]         code_q, code_d;
  logic                     eoc_q, eoc_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [ValueW-1:0] out_value_q;
  logic [CodeW-1:0]  out_code_q;
  logic              out_eoc_q;
  vote_cnt_t         out_cnt_q;
  logic              load_out;

  // submodule links
  avg_req_t  avg_req;
  avg_rsp_t  avg_rsp;
  vote_req_t vote_req;
  vote_cnt_t vote_cnt;

  // item working values
  logic                     take_item;
  logic signed [ValueW-1:0] sv;
  logic signed [ValueW-1:0] base_dv;
  logic [CntW-1:0]          base_cnt;
  logic [CodeW-1:0]         base_code;
  logic                     neg_hit;
  logic                     pos_hit;
  logic                     mid;
  logic [CntW-1:0]          dw_cnt1;
  logic [CntW-1:0]          dw_cnt2;
  logic                     dw_fire_neg;
  logic                     dw_fire_pos;
  logic [CntW-1:0]          dw_cnt;
  logic [CodeW-1:0]         dw_code;
  logic                     dw_eoc;
  logic [CodeW-1:0]         th_code;
  logic                     th_eoc;
  logic                     avg_start;
  logic                     vote_fire;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign take_item     = s_axis_tvalid && s_axis_tready &&
                         (s_axis_tuser[ChanW-1:0] == chan_q);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= RstMode;
      dwell_q   <= RstDwell;
      chan_q    <= RstChannel;
      neg_thr_q <= RstNegThr;
      pos_thr_q <= RstPosThr;
      zb_q      <= RstZeroBand;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegMode:     mode_q    <= cfg_wdata_i[ModeW-1:0];
        RegDwell:    dwell_q   <= cfg_wdata_i[CntW-1:0];
        RegChannel:  chan_q    <= cfg_wdata_i[ChanW-1:0];
        RegNegThr:   neg_thr_q <= cfg_wdata_i[SampleW-1:0];
        RegPosThr:   pos_thr_q <= cfg_wdata_i[SampleW-1:0];
        RegZeroBand: zb_q      <= cfg_wdata_i[ZbW-1:0];
        default: begin
        end
      endcase
    end
  end

  // hold the accepted item
  always_ff @(posedge clk_i) begin
    if (take_item) begin
      sample_q <= s_axis_tdata[SampleW-1:0];
      tgt_q    <= s_axis_tdata[SampleW+TgtW-1:SampleW];
      bot_q    <= s_axis_tuser[ChanW];
      cls_q    <= s_axis_tuser[ChanW+1];
      art_q    <= s_axis_tuser[ChanW+2];
      eoc_in_q <= s_axis_tlast;
    end
  end

  // trial start clears the state seen by this item
  assign sv        = {sample_q, {FracW{1'b0}}};
  assign base_dv   = bot_q ? '0 : dv_q;
  assign base_cnt  = bot_q ? '0 : cnt_q;
  assign base_code = bot_q ? CodeNone : code_q;

  // threshold hits
  assign neg_hit = ($signed(sample_q) <= $signed(neg_thr_q));
  assign pos_hit = ($signed(sample_q) >= $signed(pos_thr_q));
  assign mid     = !neg_hit && !pos_hit;

  // threshold mode
  always_comb begin
    th_code = base_code;
    th_eoc  = eoc_in_q;
    if (neg_hit) begin
      th_code = CodeNeg;
      th_eoc  = 1'b1;
    end
    if (pos_hit) begin
      th_code = CodePos;
      th_eoc  = 1'b1;
    end
    if (th_eoc && mid) begin
      th_code = CodeNeu;
    end
  end

  // dwell mode: count blocks beyond a threshold, fire on reaching the dwell
  assign dw_cnt1     = neg_hit ? sat_inc(base_cnt) : base_cnt;
  assign dw_fire_neg = neg_hit && (dw_cnt1 == dwell_q);
  assign dw_cnt2     = pos_hit ? sat_inc(dw_cnt1) : dw_cnt1;
  assign dw_fire_pos = pos_hit && (dw_cnt2 == dwell_q);
  assign dw_cnt      = mid ? '0 : dw_cnt2;

  always_comb begin
    dw_code = base_code;
    dw_eoc  = eoc_in_q;
    if (dw_fire_neg) begin
      dw_code = CodeNeg;
      dw_eoc  = 1'b1;
    end
    if (dw_fire_pos) begin
      dw_code = CodePos;
      dw_eoc  = 1'b1;
    end
    if (mid && dw_eoc) begin
      dw_code = CodeNeu;
    end
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dv_q        <= '0;
      cnt_q       <= '0;
      code_q      <= CodeNone;
      eoc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dv_q        <= dv_d;
      cnt_q       <= cnt_d;
      code_q      <= code_d;
      eoc_q       <= eoc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and decision update
  always_comb begin
    state_d   = state_q;
    dv_d      = dv_q;
    cnt_d     = cnt_q;
    code_d    = code_q;
    eoc_d     = eoc_q;
    avg_start = 1'b0;
    vote_fire = 1'b0;
    load_out  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (take_item) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        dv_d    = base_dv;
        cnt_d   = base_cnt;
        code_d  = base_code;
        eoc_d   = eoc_in_q;
        state_d = ST_VOTE;
        if (cls_q) begin
          case (mode_q)
            ModePass: begin
              dv_d   = sv;
              code_d = CodeNone;
            end
            ModeLast: begin
              if (eoc_in_q) begin
                dv_d   = sv;
                code_d = code_from_value(sv, zb_q);
              end
            end
            ModeAvg: begin
              cnt_d     = sat_inc(base_cnt);
              avg_start = 1'b1;
              state_d   = ST_AVG;
            end
            ModeThr: begin
              dv_d   = sv;
              code_d = th_code;
              eoc_d  = th_eoc;
            end
            ModeDwell: begin
              dv_d   = sv;
              cnt_d  = dw_cnt;
              code_d = dw_code;
              eoc_d  = dw_eoc;
            end
            default: begin
            end
          endcase
        end
      end
      ST_AVG: begin
        if (avg_rsp.done) begin
          dv_d    = avg_rsp.quot;
          code_d  = code_from_value(avg_rsp.quot, zb_q);
          state_d = ST_VOTE;
        end
      end
      ST_VOTE: begin
        vote_fire = cls_q && eoc_q;
        state_d   = ST_PUSH;
      end
      ST_PUSH: begin
        if (!out_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // average unit
  assign avg_req.start  = avg_start;
  assign avg_req.value  = base_dv;
  assign avg_req.count  = base_cnt;
  assign avg_req.sample = sv;

  tdd_avg u_avg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (avg_req),
    .rsp_o  (avg_rsp)
  );

  // vote counters
  assign vote_req.fire     = vote_fire;
  assign vote_req.artifact = art_q;
  assign vote_req.target   = tgt_q;
  assign vote_req.code     = code_q;

  tdd_vote u_vote (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (vote_req),
    .cnt_o  (vote_cnt)
  );

  // output register: load a result, drop it once transferred
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_value_q <= dv_q;
      out_code_q  <= code_q;
      out_eoc_q   <= eoc_q;
      out_cnt_q   <= vote_cnt;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OutPadW{1'b0}}, out_cnt_q, out_code_q, out_value_q};
  assign m_axis_tlast  = out_eoc_q;

endmodule

[sv/tdd_avg.sv]
// ----------------------------------------------------------------------------
// tdd_avg: bit-serial running average unit
// Computes (value * count + sample) / (count + 1), truncated toward zero,
// with a shift-add multiplier and a restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
module tdd_avg
  import tdd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  avg_req_t req_i,
  output avg_rsp_t rsp_o
);

  avg_state_e state_q, state_d;
  logic [StepW-1:0]         step_q, step_d;
  logic [ValueW-1:0]        mcand_q, mcand_d;
  logic [CntW-1:0]          mult_q, mult_d;
  logic [ProdW-1:0]         acc_q, acc_d;
  logic                     sgn_q, sgn_d;
  logic signed [ValueW-1:0] sv_q, sv_d;
  logic [DenW-1:0]          den_q, den_d;
  logic [NumW-1:0]          num_q, num_d;
  logic                     neg_q, neg_d;
  logic [ProdW-1:0]         dvd_q, dvd_d;
  logic [CntW-1:0]          rem_q, rem_d;

  logic [NumW-1:0]   sv_ext;
  logic [NumW-1:0]   acc_ext;
  logic [NumW-1:0]   num_mag;
  logic [DenW-1:0]   rem_shift;
  logic [DenW-1:0]   rem_sub;
  logic              q_bit;
  logic [ValueW-1:0] quot_mag;

  // operand views
  assign sv_ext    = {{(NumW - ValueW){sv_q[ValueW-1]}}, sv_q};
  assign acc_ext   = {1'b0, acc_q};
  assign num_mag   = num_q[NumW-1] ? -num_q : num_q;
  assign rem_shift = {rem_q, dvd_q[ProdW-1]};
  assign q_bit     = (rem_shift >= den_q);
  assign rem_sub   = rem_shift - den_q;
  assign quot_mag  = dvd_q[ValueW-1:0];

  // status to the core
  assign rsp_o.done = (state_q == AV_FIX);
  assign rsp_o.quot = neg_q ? -quot_mag : quot_mag;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    step_q  <= step_d;
    mcand_q <= mcand_d;
    mult_q  <= mult_d;
    acc_q   <= acc_d;
    sgn_q   <= sgn_d;
    sv_q    <= sv_d;
    den_q   <= den_d;
    num_q   <= num_d;
    neg_q   <= neg_d;
    dvd_q   <= dvd_d;
    rem_q   <= rem_d;
  end

  // sequence multiply, sum, magnitude, divide and sign fix
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    mcand_d = mcand_q;
    mult_d  = mult_q;
    acc_d   = acc_q;
    sgn_d   = sgn_q;
    sv_d    = sv_q;
    den_d   = den_q;
    num_d   = num_q;
    neg_d   = neg_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    case (state_q)
      AV_IDLE: begin
        if (req_i.start) begin
          mcand_d = req_i.value[ValueW-1] ? -req_i.value : req_i.value;
          sgn_d   = req_i.value[ValueW-1];
          mult_d  = req_i.count;
          den_d   = {1'b0, req_i.count} + 1'b1;
          sv_d    = req_i.sample;
          acc_d   = '0;
          step_d  = '0;
          state_d = AV_MUL;
        end
      end
      AV_MUL: begin
        // shift-add, count MSB first
        acc_d  = {acc_q[ProdW-2:0], 1'b0} +
                 (mult_q[CntW-1] ? {{CntW{1'b0}}, mcand_q} : {ProdW{1'b0}});
        mult_d = {mult_q[CntW-2:0], 1'b0};
        if (step_q == StepW'(MulSteps - 1)) begin
          step_d  = '0;
          state_d = AV_SUM;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      AV_SUM: begin
        num_d   = sgn_q ? (sv_ext - acc_ext) : (sv_ext + acc_ext);
        state_d = AV_ABS;
      end
      AV_ABS: begin
        neg_d   = num_q[NumW-1];
        dvd_d   = num_mag[ProdW-1:0];
        rem_d   = '0;
        step_d  = '0;
        state_d = AV_DIV;
      end
      AV_DIV: begin
        // restoring step, quotient shifts in behind the dividend
        rem_d = q_bit ? rem_sub[CntW-1:0] : rem_shift[CntW-1:0];
        dvd_d = {dvd_q[ProdW-2:0], q_bit};
        if (step_q == StepW'(DivSteps - 1)) begin
          step_d  = '0;
          state_d = AV_FIX;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      AV_FIX: begin
        state_d = AV_IDLE;
      end
      default: begin
        state_d = AV_IDLE;
      end
    endcase
  end

endmodule

[sv/tdd_vote.sv]
// ----------------------------------------------------------------------------
// tdd_vote: saturating vote counters
// Nine 16-bit counters that score the decided code against the target bits
// at the end of a class, or count the vote as invalid on an artefact.
// ----------------------------------------------------------------------------
module tdd_vote
  import tdd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  vote_req_t req_i,
  output vote_cnt_t cnt_o
);

  vote_cnt_t           cnt_q, cnt_d;
  logic [NumVotes-1:0] inc;
  logic                has_verdict;
  logic                verdict_right;

  // the first category present in the target, neutral, negative, then positive, decides the total
  always_comb begin
    has_verdict   = 1'b1;
    verdict_right = 1'b0;
    if (req_i.target[BitNeu]) begin
      verdict_right = req_i.code[BitNeu];
    end else if (req_i.target[BitNeg]) begin
      verdict_right = req_i.code[BitNeg];
    end else if (req_i.target[BitPos]) begin
      verdict_right = req_i.code[BitPos];
    end else begin
      has_verdict = 1'b0;
    end
  end

  // select the counters to bump
  always_comb begin
    inc = '0;
    if (req_i.fire) begin
      if (req_i.artifact) begin
        inc[VoteInvalid] = 1'b1;
      end else begin
        inc[VotePosRight] = req_i.target[BitPos] &  req_i.code[BitPos];
        inc[VotePosWrong] = req_i.target[BitPos] & ~req_i.code[BitPos];
        inc[VoteNegRight] = req_i.target[BitNeg] &  req_i.code[BitNeg];
        inc[VoteNegWrong] = req_i.target[BitNeg] & ~req_i.code[BitNeg];
        inc[VoteNeuRight] = req_i.target[BitNeu] &  req_i.code[BitNeu];
        inc[VoteNeuWrong] = req_i.target[BitNeu] & ~req_i.code[BitNeu];
        inc[VoteTotRight] = has_verdict &  verdict_right;
        inc[VoteTotWrong] = has_verdict & ~verdict_right;
      end
    end
  end

  // saturating increment
  always_comb begin
    for (int i = 0; i < NumVotes; i++) begin
      cnt_d[i] = inc[i] ? sat_inc(cnt_q[i]) : cnt_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign cnt_o = cnt_q;

endmodule

[sim/tb_threshold_dwell_decider_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_threshold_dwell_decider_core: self-checking bench of the decision core
// Drives tagged samples through the input stream, predicts every decision
// transfer with an independent model of the modes, the code band and the vote
// tally, and compares each result field by field. A directed table comes
// first, then a dwell burst and random trials under varied settings with
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_threshold_dwell_decider_core;
  import tdd_pkg::*;

  localparam int QuietLimit = 5000;
  localparam int DrainGap   = 80;
  localparam int BurstLen   = 16;
  localparam int SegItems   = 40;
  localparam logic [ModeW-1:0] ModeUnused = 3'd5;

  typedef struct packed {
    logic [ChanW-1:0]          chan;
    logic signed [SampleW-1:0] smp;
    logic                      bot;
    logic                      cls;
    logic                      eoc;
    logic                      art;
    logic [TgtW-1:0]           tgt;
  } sample_item_t;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [CodeW-1:0]  code;
    logic              eoc;
    vote_cnt_t         votes;
  } decision_t;

  typedef struct {
    logic                is_cfg;
    logic [CfgIdxW-1:0]  reg_idx;
    logic [CfgDataW-1:0] reg_val;
    sample_item_t        item;
    logic                typed;
    int                  typed_value;
    logic [CodeW-1:0]    typed_code;
    logic                typed_eoc;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [InUserW-1:0]  s_axis_tuser = '0;
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  // model configuration
  logic [ModeW-1:0]          mode_r;
  logic [CntW-1:0]           dwell_r;
  logic [ChanW-1:0]          chan_r;
  logic signed [SampleW-1:0] negthr_r;
  logic signed [SampleW-1:0] posthr_r;
  logic [ZbW-1:0]            zband_r;

  // model state
  int               dec_val;
  logic [CntW-1:0]  blk_cnt;
  logic [CodeW-1:0] cur_code;
  vote_cnt_t        tally;

  decision_t pending_decisions[$];
  stim_row_t script[$];
  int        mismatch_count = 0;
  int        quiet_cycles = 0;
  int        idle_pct = 0;
  int        stall_pct = 0;
  int        fed = 0;

  string vote_names[NumVotes] = '{"pos_right", "pos_wrong", "neg_right", "neg_wrong",
                                  "neutral_right", "neutral_wrong", "total_right",
                                  "total_wrong", "total_invalid"};

  threshold_dwell_decider_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  // stall the decision stream at random
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
               QuietLimit, pending_decisions.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // compare each decision transfer with the oldest prediction
  always @(posedge clk_i) begin
    decision_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_decisions.size() == 0) begin
        $display("%0t: unexpected result, expected none, got tdata %h tlast %b", $time,
                 m_axis_tdata, m_axis_tlast);
        mismatch_count++;
      end else begin
        want = pending_decisions.pop_front();
        check_field("result_value", longint'($signed(want.value)),
                    longint'($signed(m_axis_tdata[ValueW-1:0])));
        check_field("result_code", longint'(want.code),
                    longint'(m_axis_tdata[ValueW +: CodeW]));
        check_field("end_of_class_out", longint'(want.eoc), longint'(m_axis_tlast));
        for (int k = 0; k < NumVotes; k++) begin
          check_field(vote_names[k], longint'(want.votes[k]),
                      longint'(m_axis_tdata[ValueW + CodeW + CntW * k +: CntW]));
        end
        check_field("tdata pad", longint'(0),
                    longint'(m_axis_tdata[OutDataW-1:OutBitsW]));
      end
    end
  end

  function automatic logic [CntW-1:0] bump16(input logic [CntW-1:0] c);
    return (c == {CntW{1'b1}}) ? c : c + 1'b1;
  endfunction

  function automatic logic [CodeW-1:0] band_code(input int v);
    int zb;
    zb = int'(zband_r);
    if (v > zb) return CodePos;
    if (v < -zb) return CodeNeg;
    return CodeNeu;
  endfunction

  function automatic void apply_reg(input logic [CfgIdxW-1:0] idx,
                                    input logic [CfgDataW-1:0] val);
    case (idx)
      RegMode:     mode_r   = val[ModeW-1:0];
      RegDwell:    dwell_r  = val[CntW-1:0];
      RegChannel:  chan_r   = val[ChanW-1:0];
      RegNegThr:   negthr_r = val[SampleW-1:0];
      RegPosThr:   posthr_r = val[SampleW-1:0];
      RegZeroBand: zband_r  = val[ZbW-1:0];
      default: ;
    endcase
  endfunction

  // advance the model by one sample; return 1 when a decision transfer follows
  function automatic logic decide_step(input sample_item_t it, output decision_t d);
    int        s;
    int        sv;
    logic      eoc;
    longint    num;
    longint    den;
    int        verdict;
    logic [1:0] cat_bit;
    d = '0;
    if (it.chan != chan_r) return 1'b0;
    s   = int'(it.smp);
    sv  = s * 256;
    eoc = it.eoc;
    if (it.bot) begin
      dec_val  = 0;
      blk_cnt  = '0;
      cur_code = CodeNone;
    end
    if (it.cls) begin
      case (mode_r)
        ModePass: begin
          dec_val  = sv;
          cur_code = CodeNone;
        end
        ModeLast: begin
          if (eoc) begin
            dec_val  = sv;
            cur_code = band_code(sv);
          end
        end
        ModeAvg: begin
          num     = longint'(dec_val) * longint'(blk_cnt) + longint'(sv);
          den     = longint'(blk_cnt) + 1;
          dec_val = int'(num / den);
          blk_cnt = bump16(blk_cnt);
          cur_code = band_code(dec_val);
        end
        ModeThr: begin
          dec_val = sv;
          if (it.smp <= negthr_r) begin
            cur_code = CodeNeg;
            eoc = 1'b1;
          end
          if (it.smp >= posthr_r) begin
            cur_code = CodePos;
            eoc = 1'b1;
          end
          if (eoc && it.smp > negthr_r && it.smp < posthr_r) cur_code = CodeNeu;
        end
        ModeDwell: begin
          dec_val = sv;
          if (it.smp <= negthr_r) begin
            blk_cnt = bump16(blk_cnt);
            if (blk_cnt == dwell_r) begin
              cur_code = CodeNeg;
              eoc = 1'b1;
            end
          end
          if (it.smp >= posthr_r) begin
            blk_cnt = bump16(blk_cnt);
            if (blk_cnt == dwell_r) begin
              cur_code = CodePos;
              eoc = 1'b1;
            end
          end
          if (it.smp > negthr_r && it.smp < posthr_r) begin
            blk_cnt = '0;
            if (eoc) cur_code = CodeNeu;
          end
        end
        default: ;
      endcase
      // score the vote: positive, negative, then neutral; the last match decides
      if (eoc) begin
        if (it.art) begin
          tally[VoteInvalid] = bump16(tally[VoteInvalid]);
        end else begin
          verdict = 0;
          for (int i = 0; i < 3; i++) begin
            cat_bit = 2'((i == 0) ? BitPos : (i == 1) ? BitNeg : BitNeu);
            if (it.tgt[cat_bit]) begin
              if (cur_code[cat_bit]) begin
                tally[2 * i] = bump16(tally[2 * i]);
                verdict = 1;
              end else begin
                tally[2 * i + 1] = bump16(tally[2 * i + 1]);
                verdict = -1;
              end
            end
          end
          if (verdict == 1) tally[VoteTotRight] = bump16(tally[VoteTotRight]);
          if (verdict == -1) tally[VoteTotWrong] = bump16(tally[VoteTotWrong]);
        end
      end
    end
    d.value = dec_val[ValueW-1:0];
    d.code  = cur_code;
    d.eoc   = eoc;
    d.votes = tally;
    return 1'b1;
  endfunction

  // offer one sample and hold it until the transfer; valid stays high afterwards
  task automatic put_item(input sample_item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW - TgtW - SampleW){1'b0}}, it.tgt, it.smp};
    s_axis_tuser  <= {it.art, it.cls, it.bot, it.chan};
    s_axis_tlast  <= it.eoc;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drive_item(input sample_item_t it);
    decision_t d;
    if (decide_step(it, d)) begin
      pending_decisions.push_back(d);
      fed++;
    end
    put_item(it);
  endtask

  // drop valid, let every result out, then give the block time to go idle
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_decisions.size() != 0) @(posedge clk_i);
    repeat (DrainGap) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    apply_reg(idx, val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [CfgDataW-1:0] thr_word(input int v);
    return {2'b00, 16'(v)};
  endfunction

  function automatic sample_item_t mk_item(input int chan, input int smp, input bit bot,
                                           input bit cls, input bit eoc, input bit art,
                                           input int tgt);
    sample_item_t it;
    it.chan = ChanW'(chan);
    it.smp  = SampleW'(smp);
    it.bot  = bot;
    it.cls  = cls;
    it.eoc  = eoc;
    it.art  = art;
    it.tgt  = TgtW'(tgt);
    return it;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CfgIdxW-1:0] idx,
                                        input logic [CfgDataW-1:0] val);
    stim_row_t r;
    r = '{default: '0};
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic stim_row_t item_row(input sample_item_t it);
    stim_row_t r;
    r = '{default: '0};
    r.item = it;
    return r;
  endfunction

  function automatic stim_row_t chk_row(input sample_item_t it, input int value,
                                        input logic [CodeW-1:0] code, input bit eoc);
    stim_row_t r;
    r = item_row(it);
    r.typed       = 1'b1;
    r.typed_value = value;
    r.typed_code  = code;
    r.typed_eoc   = eoc;
    return r;
  endfunction

  function automatic logic signed [SampleW-1:0] pick_sample();
    int v;
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 3))
          0: v = -32768;
          1: v = 32767;
          2: v = 0;
          default: v = -1;
        endcase
      end
      1: v = int'(negthr_r) + int'($urandom_range(0, 4)) - 2;
      2: v = int'(posthr_r) + int'($urandom_range(0, 4)) - 2;
      3: v = int'($urandom_range(0, 65535)) - 32768;
      default: v = int'($urandom_range(0, 600)) - 300;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return SampleW'(v);
  endfunction

  // write every register with the extremes or a random setting
  task automatic choose_setup(input int seg);
    int neg;
    int pos;
    if (seg == 0) begin
      cfg_write(RegMode, CfgDataW'(ModePass));
      cfg_write(RegDwell, '0);
      cfg_write(RegChannel, '0);
      cfg_write(RegNegThr, thr_word(-32768));
      cfg_write(RegPosThr, thr_word(-32768));
      cfg_write(RegZeroBand, '0);
    end else if (seg == 1) begin
      cfg_write(RegMode, CfgDataW'(ModeDwell));
      cfg_write(RegDwell, 18'd65535);
      cfg_write(RegChannel, 18'd1023);
      cfg_write(RegNegThr, thr_word(32767));
      cfg_write(RegPosThr, thr_word(32767));
      cfg_write(RegZeroBand, 18'd261888);
    end else begin
      cfg_write(RegMode, CfgDataW'(($urandom_range(0, 9) == 0) ? $urandom_range(5, 7)
                                                               : $urandom_range(0, 4)));
      case ($urandom_range(0, 4))
        0: cfg_write(RegDwell, 18'd65535);
        1: cfg_write(RegDwell, CfgDataW'($urandom_range(0, 65535)));
        default: cfg_write(RegDwell, CfgDataW'($urandom_range(0, 5)));
      endcase
      cfg_write(RegChannel, ($urandom_range(0, 3) == 0) ? 18'd1023
                                                        : CfgDataW'($urandom_range(0, 1023)));
      case ($urandom_range(0, 5))
        4: begin
          neg = $urandom_range(0, 200);
          pos = -int'($urandom_range(0, 200));
        end
        5: begin
          neg = int'($urandom_range(0, 65535)) - 32768;
          pos = int'($urandom_range(0, 65535)) - 32768;
        end
        default: begin
          neg = -int'($urandom_range(0, 300));
          pos = $urandom_range(0, 300);
        end
      endcase
      cfg_write(RegNegThr, thr_word(neg));
      cfg_write(RegPosThr, thr_word(pos));
      case ($urandom_range(0, 3))
        0: cfg_write(RegZeroBand, CfgDataW'($urandom_range(0, 261888)));
        1: cfg_write(RegZeroBand, ($urandom_range(0, 1) != 0) ? 18'd261888 : 18'd0);
        default: cfg_write(RegZeroBand, CfgDataW'($urandom_range(0, 80000)));
      endcase
    end
  endtask

  // one trial: begin block, blocks of the class window, end of class near the end
  task automatic run_trial();
    int           len;
    sample_item_t it;
    len = $urandom_range(1, 8);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 5) == 0) begin
        it = mk_item($urandom_range(0, 1023), $urandom_range(0, 65535),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     $urandom_range(0, 15));
        drive_item(it);
      end
      if ($urandom_range(0, 9) == 0) begin
        it = mk_item(int'(chan_r), int'(pick_sample()), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), $urandom_range(0, 15));
      end else begin
        it = mk_item(int'(chan_r), int'(pick_sample()), k == 0,
                     (k == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 9) != 0),
                     (k == len - 1) ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 9) == 0),
                     $urandom_range(0, 9) == 0, $urandom_range(0, 15));
      end
      drive_item(it);
    end
  endtask

  initial begin
    decision_t    want;

    mode_r   = RstMode;
    dwell_r  = RstDwell;
    chan_r   = RstChannel;
    negthr_r = RstNegThr;
    posthr_r = RstPosThr;
    zband_r  = RstZeroBand;
    dec_val  = 0;
    blk_cnt  = '0;
    cur_code = CodeNone;
    tally    = '0;

    // directed table: reset settings first, then every mode and its corner cases
    script.push_back(chk_row(mk_item(0, 0, 1, 0, 0, 0, 0), 0, CodeNone, 0));
    script.push_back(item_row(mk_item(5, -1, 1, 1, 1, 0, 4)));
    script.push_back(chk_row(mk_item(0, 32767, 0, 1, 0, 0, 0), 8388352, CodePos, 0));
    script.push_back(item_row(mk_item(0, -32768, 0, 1, 1, 0, 4)));
    script.push_back(cfg_row(RegMode, CfgDataW'(ModePass)));
    script.push_back(chk_row(mk_item(0, -32768, 0, 1, 0, 0, 0), -8388608, CodeNone, 0));
    script.push_back(cfg_row(RegMode, CfgDataW'(ModeLast)));
    script.push_back(item_row(mk_item(0, 100, 0, 1, 0, 0, 0)));
    script.push_back(chk_row(mk_item(0, 1, 0, 1, 1, 0, 2), 256, CodePos, 1));
    script.push_back(chk_row(mk_item(0, 0, 0, 1, 1, 1, 15), 0, CodeNeu, 1));
    script.push_back(cfg_row(RegMode, CfgDataW'(ModeThr)));
    script.push_back(chk_row(mk_item(0, 80, 0, 1, 0, 0, 4), 20480, CodePos, 1));
    script.push_back(chk_row(mk_item(0, -80, 0, 1, 0, 0, 1), -20480, CodeNeg, 1));
    script.push_back(item_row(mk_item(0, 0, 0, 1, 0, 0, 0)));
    script.push_back(chk_row(mk_item(0, 0, 0, 1, 1, 0, 15), 0, CodeNeu, 1));
    // overlapping thresholds: both hits, positive wins
    script.push_back(cfg_row(RegNegThr, thr_word(100)));
    script.push_back(cfg_row(RegPosThr, thr_word(-100)));
    script.push_back(chk_row(mk_item(0, 0, 0, 1, 0, 0, 0), 0, CodePos, 1));
    script.push_back(cfg_row(RegMode, CfgDataW'(ModeDwell)));
    script.push_back(cfg_row(RegDwell, 18'd2));
    script.push_back(item_row(mk_item(0, 0, 1, 1, 0, 0, 4)));
    // dwell of zero never fires
    script.push_back(cfg_row(RegNegThr, thr_word(-80)));
    script.push_back(cfg_row(RegPosThr, thr_word(80)));
    script.push_back(cfg_row(RegDwell, 18'd0));
    script.push_back(item_row(mk_item(0, 90, 0, 1, 0, 0, 4)));
    script.push_back(cfg_row(RegDwell, 18'd3));
    script.push_back(item_row(mk_item(0, 200, 1, 1, 0, 0, 4)));
    script.push_back(item_row(mk_item(0, 200, 0, 1, 0, 0, 4)));
    script.push_back(item_row(mk_item(0, 200, 0, 1, 0, 0, 4)));
    script.push_back(item_row(mk_item(0, 200, 0, 1, 0, 0, 4)));
    script.push_back(item_row(mk_item(0, 10, 0, 1, 0, 0, 1)));
    script.push_back(item_row(mk_item(0, -32768, 0, 1, 0, 0, 1)));
    script.push_back(cfg_row(RegMode, CfgDataW'(ModeUnused)));
    script.push_back(item_row(mk_item(0, 5, 0, 1, 1, 0, 4)));
    script.push_back(cfg_row(RegZeroBand, 18'd261888));
    script.push_back(cfg_row(RegChannel, 18'd1023));
    script.push_back(cfg_row(RegMode, CfgDataW'(ModeAvg)));
    script.push_back(chk_row(mk_item(1023, 1000, 1, 1, 0, 0, 0), 256000, CodeNeu, 0));
    script.push_back(item_row(mk_item(0, 7, 1, 1, 1, 0, 4)));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    stall_pct = 27;
    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        settle_block();
        cfg_write(script[i].reg_idx, script[i].reg_val);
      end else begin
        if (decide_step(script[i].item, want)) begin
          if (script[i].typed) begin
            want.value = ValueW'(script[i].typed_value);
            want.code  = script[i].typed_code;
            want.eoc   = script[i].typed_eoc;
          end
          pending_decisions.push_back(want);
        end
        put_item(script[i].item);
      end
    end

    // dwell run past the dwell count: the hit fires once and never again
    stall_pct = 0;
    settle_block();
    cfg_write(RegMode, CfgDataW'(ModeDwell));
    cfg_write(RegDwell, 18'd5);
    cfg_write(RegChannel, '0);
    cfg_write(RegNegThr, thr_word(-80));
    cfg_write(RegPosThr, thr_word(80));
    for (int n = 0; n < BurstLen; n++) begin
      drive_item(mk_item(0, 200, n == 0, 1, 1, 0, 7));
    end

    // random trials over idling phases and settings
    for (int seg = 0; seg < 8; seg++) begin
      case (seg / 2)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 59; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 59; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase
      settle_block();
      choose_setup(seg);
      fed = 0;
      while (fed < SegItems) begin
        // hold the sender now and then until the block has caught up
        if ($urandom_range(0, 29) == 0) begin
          s_axis_tvalid <= 1'b0;
          @(posedge clk_i);
          while (pending_decisions.size() != 0) @(posedge clk_i);
        end
        run_trial();
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_decisions.size() != 0) @(posedge clk_i);
    repeat (DrainGap) @(posedge clk_i);

    if (mismatch_count == 0 && pending_decisions.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/tdd_pkg.sv
sv/tdd_avg.sv
sv/tdd_vote.sv
sv/threshold_dwell_decider_core.sv
sim/tb_threshold_dwell_decider_core.sv
